[src/lzwd_pkg.sv]
package lzwd_pkg;

    // Field widths of the stream format, bus widths and queue depth
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 12;
    localparam int MIN_W    = 4;
    localparam int LEN_W    = 5;
    localparam int TOTAL_W  = 32;
    localparam int HDR_W    = 3;
    localparam int FLAG_W   = 16;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int FIFO_DEPTH = 4;

    // Register reset values
    localparam logic [POS_W-1:0]  START_POS_RESET = 12'hFEE;
    localparam logic [MIN_W-1:0]  MIN_MATCH_RESET = 4'd3;
    localparam logic [BYTE_W-1:0] FILL_RESET      = 8'h00;

    // Longest run one pair may produce
    localparam logic [LEN_W-1:0] MAX_RUN = 5'd18;

    // Header counter value as the fourth length byte arrives, then in the payload
    localparam logic [HDR_W-1:0] HDR_LAST    = 3'd3;
    localparam logic [HDR_W-1:0] HDR_PAYLOAD = 3'd4;

    // Register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_START_POS = 2'd0,
        REG_MIN_MATCH = 2'd1,
        REG_FILL      = 2'd2
    } reg_idx_t;

    // Work handed from the parser to the copy engine
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_LIT   = 2'd1,
        CMD_COPY  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [POS_W-1:0]   pos;    // copy offset or stream start position
        logic [BYTE_W-1:0]  data;   // literal byte or fill byte
        logic [LEN_W-1:0]   len;    // copy length
        logic               done;   // this word ends the stream
    } cmd_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_COPY = 1'b1
    } back_state_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

[src/lzwd_in_if.sv]
interface lzwd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

[src/lzwd_out_if.sv]
interface lzwd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        stream_done;
    logic [31:0] decoded_total;

    modport source (output valid, output out_byte, output run_last, output stream_done,
                    output decoded_total, input ready);
    modport sink   (input valid, input out_byte, input run_last, input stream_done,
                    input decoded_total, output ready);
endinterface

[src/lzwd_front.sv]
module lzwd_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [lzwd_pkg::BYTE_W-1:0]  in_byte,
    output logic                         in_ready,
    input  logic [lzwd_pkg::POS_W-1:0]   start_pos,
    input  logic [lzwd_pkg::MIN_W-1:0]   min_match,
    input  logic [lzwd_pkg::BYTE_W-1:0]  fill_value,
    input  logic                         fifo_full,
    output logic                         cmd_push,
    output lzwd_pkg::cmd_t               cmd
);
    import lzwd_pkg::*;

    logic [HDR_W-1:0]     hdr_cnt_reg,   hdr_cnt_next;
    logic [23:0]          len_acc_reg,   len_acc_next;
    logic [TOTAL_W-1:0]   remain_reg,    remain_next;
    logic [FLAG_W-1:0]    flag_reg,      flag_next;
    logic                 pair_pend_reg, pair_pend_next;
    logic [BYTE_W-1:0]    pair_low_reg,  pair_low_next;

    logic                 accept;
    logic [TOTAL_W-1:0]   full_len;
    logic [LEN_W-1:0]     len_sum;
    logic                 last;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && !fifo_full;
    assign full_len = {in_byte, len_acc_reg};
    assign len_sum  = {1'b0, in_byte[3:0]} + {1'b0, min_match};
    assign last     = (remain_reg == TOTAL_W'(1));

    // Classify each word: header, flag, literal, pair half
    always_comb
    begin
        hdr_cnt_next   = hdr_cnt_reg;
        len_acc_next   = len_acc_reg;
        remain_next    = remain_reg;
        flag_next      = flag_reg;
        pair_pend_next = pair_pend_reg;
        pair_low_next  = pair_low_reg;
        cmd_push       = 1'b0;
        cmd            = '0;
        cmd.kind       = CMD_LIT;
        if (accept)
        begin
            if (hdr_cnt_reg != HDR_PAYLOAD)
            begin
                case (hdr_cnt_reg)
                    3'd0:    len_acc_next[7:0]   = in_byte;
                    3'd1:    len_acc_next[15:8]  = in_byte;
                    3'd2:    len_acc_next[23:16] = in_byte;
                    default: len_acc_next        = len_acc_reg;
                endcase
                if (hdr_cnt_reg == HDR_LAST)
                begin
                    remain_next    = full_len;
                    flag_next      = '0;
                    pair_pend_next = 1'b0;
                    pair_low_next  = '0;
                    cmd_push       = 1'b1;
                    cmd.kind       = CMD_START;
                    cmd.pos        = start_pos;
                    cmd.data       = fill_value;
                    hdr_cnt_next   = (full_len == '0) ? '0 : HDR_PAYLOAD;
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_reg + HDR_W'(1);
                end
            end
            else
            begin
                remain_next = remain_reg - TOTAL_W'(1);
                if (pair_pend_reg)
                begin
                    // second pair byte: offset high nibble and length
                    pair_pend_next = 1'b0;
                    cmd.kind       = CMD_COPY;
                    cmd.pos        = {in_byte[7:4], pair_low_reg};
                    cmd.len        = (len_sum > MAX_RUN) ? MAX_RUN : len_sum;
                    cmd.done       = last;
                    cmd_push       = (len_sum != '0);
                end
                else if (!flag_reg[8])
                begin
                    flag_next = {8'hFF, in_byte};
                end
                else
                begin
                    if (flag_reg[0])
                    begin
                        cmd_push = 1'b1;
                        cmd.kind = CMD_LIT;
                        cmd.data = in_byte;
                        cmd.done = last;
                    end
                    else
                    begin
                        pair_low_next  = in_byte;
                        pair_pend_next = 1'b1;
                    end
                    flag_next = flag_reg >> 1;
                end
                if (last)
                begin
                    hdr_cnt_next   = '0;
                    pair_pend_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg   <= '0;
            len_acc_reg   <= '0;
            remain_reg    <= '0;
            flag_reg      <= '0;
            pair_pend_reg <= 1'b0;
            pair_low_reg  <= '0;
        end
        else
        begin
            hdr_cnt_reg   <= hdr_cnt_next;
            len_acc_reg   <= len_acc_next;
            remain_reg    <= remain_next;
            flag_reg      <= flag_next;
            pair_pend_reg <= pair_pend_next;
            pair_low_reg  <= pair_low_next;
        end
    end

endmodule

[src/lzwd_cmd_fifo.sv]
module lzwd_cmd_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lzwd_pkg::cmd_t        push_cmd,
    input  logic                  pop,
    output lzwd_pkg::cmd_t        head_cmd,
    output lzwd_pkg::fifo_stat_t  stat
);
    import lzwd_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    cmd_t               slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg,  count_next;

    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign stat.push  = push;
    assign stat.pop   = pop;
    assign stat.full  = (count_reg == (PTR_W+1)'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[src/lzwd_back.sv]
module lzwd_back #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  lzwd_pkg::cmd_t                cmd,
    output logic                          cmd_pop,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [lzwd_pkg::BYTE_W-1:0]   out_byte,
    output logic                          run_last,
    output logic                          stream_done,
    output logic [lzwd_pkg::TOTAL_W-1:0]  decoded_total
);
    import lzwd_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);

    logic [BYTE_W-1:0]   window_mem [WINDOW_DEPTH];
    logic [BYTE_W-1:0]   mem_q_reg;

    back_state_t         state_reg,   state_next;
    logic [AW-1:0]       wp_reg,      wp_next;
    logic [AW-1:0]       start_reg,   start_next;
    logic [BYTE_W-1:0]   fill_reg,    fill_next;
    logic [AW:0]         cnt_reg,     cnt_next;
    logic [TOTAL_W-1:0]  total_reg,   total_next;
    logic [AW-1:0]       rd_addr_reg, rd_addr_next;
    logic [LEN_W-1:0]    remain_reg,  remain_next;
    logic                done_reg,    done_next;
    logic                hit_reg,     hit_next;
    logic [BYTE_W-1:0]   fwd_reg,     fwd_next;
    logic                written_reg, written_next;
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                run_last_reg;
    logic                done_out_reg;
    logic [TOTAL_W-1:0]  total_out_reg;

    logic                out_free;
    logic                emit;
    logic [BYTE_W-1:0]   emit_byte;
    logic                emit_last;
    logic                emit_done;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       rd_dist;
    logic                rd_written;

    assign out_free      = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign run_last      = run_last_reg;
    assign stream_done   = done_out_reg;
    assign decoded_total = total_out_reg;

    // An entry holds stream data only if it lies in the span written since start
    assign rd_dist    = rd_addr - start_reg;
    assign rd_written = cnt_reg[AW] || ({1'b0, rd_dist} < cnt_reg);

    // Command execution: literals go out at once and copies stream one byte a cycle, while the output is free
    always_comb
    begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        start_next   = start_reg;
        fill_next    = fill_reg;
        cnt_next     = cnt_reg;
        total_next   = total_reg;
        rd_addr_next = rd_addr_reg;
        remain_next  = remain_reg;
        done_next    = done_reg;
        hit_next     = hit_reg;
        fwd_next     = fwd_reg;
        written_next = written_reg;
        cmd_pop      = 1'b0;
        emit         = 1'b0;
        emit_byte    = '0;
        emit_last    = 1'b0;
        emit_done    = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = rd_addr_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        CMD_START:
                        begin
                            cmd_pop    = 1'b1;
                            wp_next    = AW'(cmd.pos);
                            start_next = AW'(cmd.pos);
                            fill_next  = cmd.data;
                            cnt_next   = '0;
                            total_next = '0;
                        end
                        CMD_LIT:
                        begin
                            if (out_free)
                            begin
                                cmd_pop   = 1'b1;
                                emit      = 1'b1;
                                emit_byte = cmd.data;
                                emit_last = 1'b1;
                                emit_done = cmd.done;
                            end
                        end
                        CMD_COPY:
                        begin
                            // first read; no write can land in this cycle
                            cmd_pop      = 1'b1;
                            rd_en        = 1'b1;
                            rd_addr      = AW'(cmd.pos);
                            rd_addr_next = rd_addr;
                            hit_next     = 1'b0;
                            written_next = rd_written;
                            remain_next  = cmd.len;
                            done_next    = cmd.done;
                            state_next   = BK_COPY;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_COPY:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_byte   = hit_reg ? fwd_reg : (written_reg ? mem_q_reg : fill_reg);
                    emit_last   = (remain_reg == LEN_W'(1));
                    emit_done   = done_reg;
                    remain_next = remain_reg - LEN_W'(1);
                    if (remain_reg != LEN_W'(1))
                    begin
                        // next read; forward if it hits the byte written now
                        rd_en        = 1'b1;
                        rd_addr      = rd_addr_reg + AW'(1);
                        rd_addr_next = rd_addr;
                        hit_next     = (rd_addr == wp_reg);
                        fwd_next     = emit_byte;
                        written_next = rd_written;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        // Every emitted byte is stored and counted
        if (emit)
        begin
            wp_next    = wp_reg + AW'(1);
            total_next = total_reg + TOTAL_W'(1);
            if (!cnt_reg[AW])
            begin
                cnt_next = cnt_reg + (AW+1)'(1);
            end
        end

        out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            wp_reg        <= AW'(START_POS_RESET);
            start_reg     <= AW'(START_POS_RESET);
            fill_reg      <= FILL_RESET;
            cnt_reg       <= '0;
            total_reg     <= '0;
            rd_addr_reg   <= '0;
            remain_reg    <= '0;
            done_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            written_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            start_reg     <= start_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            rd_addr_reg   <= rd_addr_next;
            remain_reg    <= remain_next;
            done_reg      <= done_next;
            hit_reg       <= hit_next;
            written_reg   <= written_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output word and forwarded byte
    always_ff @(posedge clk)
    begin
        fwd_reg <= fwd_next;
        if (emit)
        begin
            out_byte_reg  <= emit_byte;
            run_last_reg  <= emit_last;
            done_out_reg  <= emit_done;
            total_out_reg <= total_next;
        end
    end

    // Window memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            window_mem[wp_reg] <= emit_byte;
        end
        if (rd_en)
        begin
            mem_q_reg <= window_mem[rd_addr];
        end
    end

endmodule

[src/lzss_window_decoder_unit.sv]
// LZSS decoder with a 4096-byte window. Each input word is one compressed
// byte: four little-endian length bytes, then flag bytes and tokens. A parser
// classifies each word and queues a command (stream start, literal, or copy)
// into a four-entry queue; a copy engine runs the commands against the window
// RAM and drives a registered output word. Input words are taken at one per
// cycle while the queue has room. A literal leaves once the output is free;
// a copy first reads the window RAM, then streams one byte per cycle while
// the output is free, set by the single window RAM port pair; header, flag
// and first-pair words produce no output byte. Sustained rate is bound by the
// output at one decoded byte per cycle. Stream start clears no RAM: entries
// not yet written in the stream read back as the fill value, so there is no
// clearing pass. Configuration registers are at byte addresses 0 (start
// position), 4 (minimum match) and 8 (fill value) and must only be written
// while the decoder is idle.
module lzss_window_decoder_unit #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    lzwd_in_if.sink                       in_ch,
    lzwd_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lzwd_pkg::PADDR_W-1:0]  paddr,
    input  logic [lzwd_pkg::PDATA_W-1:0]  pwdata,
    output logic [lzwd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import lzwd_pkg::*;

    logic [POS_W-1:0]   start_pos_reg;
    logic [MIN_W-1:0]   min_match_reg;
    logic [BYTE_W-1:0]  fill_reg;
    logic               cfg_wr;

    logic               cmd_push;
    cmd_t               push_cmd;
    cmd_t               head_cmd;
    logic               cmd_pop;
    fifo_stat_t         fifo_stat;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pos_reg <= START_POS_RESET;
            min_match_reg <= MIN_MATCH_RESET;
            fill_reg      <= FILL_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_START_POS: start_pos_reg <= pwdata[POS_W-1:0];
                REG_MIN_MATCH: min_match_reg <= pwdata[MIN_W-1:0];
                REG_FILL:      fill_reg      <= pwdata[BYTE_W-1:0];
                default:       fill_reg      <= fill_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_START_POS: prdata = PDATA_W'(start_pos_reg);
            REG_MIN_MATCH: prdata = PDATA_W'(min_match_reg);
            REG_FILL:      prdata = PDATA_W'(fill_reg);
            default:       prdata = '0;
        endcase
    end

    // Parser
    lzwd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_byte    (in_ch.in_byte),
        .in_ready   (in_ch.ready),
        .start_pos  (start_pos_reg),
        .min_match  (min_match_reg),
        .fill_value (fill_reg),
        .fifo_full  (fifo_stat.full),
        .cmd_push   (cmd_push),
        .cmd        (push_cmd)
    );

    // Command queue
    lzwd_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .pop      (cmd_pop),
        .head_cmd (head_cmd),
        .stat     (fifo_stat)
    );

    // Copy engine
    lzwd_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (!fifo_stat.empty),
        .cmd           (head_cmd),
        .cmd_pop       (cmd_pop),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .out_byte      (out_ch.out_byte),
        .run_last      (out_ch.run_last),
        .stream_done   (out_ch.stream_done),
        .decoded_total (out_ch.decoded_total)
    );

    // Queue never written when full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_stat.push |-> !fifo_stat.full)
        else $error("command queue overflow");

    // Queue never read when empty
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_stat.pop |-> !fifo_stat.empty)
        else $error("command queue underflow");

    // A minimum-match register write lands in the next cycle
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && paddr[3:2] == REG_MIN_MATCH) |=> min_match_reg == $past(pwdata[MIN_W-1:0]))
        else $error("min_match write lost");

endmodule
